// File: rtl/core/prng_pkg.sv
// Package for the random number core: widths, request mode codes,
// register indexes, reset seed and the generator step function.
// Has no dependencies; used by prng_with_range_reduction_core.
package prng_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned CNT_W  = 6;

   // Request modes carried in the request tuser field.
   localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESEED = 2'd2;

   // Register indexes on the configuration channel.
   localparam logic CSR_SEED_LOW  = 1'b0;
   localparam logic CSR_SEED_HIGH = 1'b1;

   localparam logic [WORD_W-1:0] SEED_RESET = 64'hFEED_FACE_CAFE_BEEF;

   // Rotate and shift amounts of the generator step.
   localparam int unsigned ROT_A   = 24;
   localparam int unsigned SHIFT_B = 16;
   localparam int unsigned ROT_C   = 37;

   // Last iteration index of the shift-subtract divider.
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

   typedef struct packed {
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
   } gen_state_type;

   // One xoroshiro128+ state advance.
   function automatic gen_state_type gen_advance(input gen_state_type cur);
      gen_state_type     nxt;
      logic [WORD_W-1:0] mix;
      logic [WORD_W-1:0] rot_a;
      mix         = cur.word_b ^ cur.word_a;
      rot_a       = (cur.word_a << ROT_A) | (cur.word_a >> (WORD_W - ROT_A));
      nxt.word_a  = rot_a ^ mix ^ (mix << SHIFT_B);
      nxt.word_b  = (mix << ROT_C) | (mix >> (WORD_W - ROT_C));
      return nxt;
   endfunction

endpackage

// File: rtl/core/prng_with_range_reduction_core.sv
// Random number core: xoroshiro128+ generator with range reduction through a
// shared shift-subtract remainder unit. Depends on prng_pkg.
// Raw draws, zero-span ranged draws, reseeds and the unused mode skip the divider;
// other ranged draws load it, run 64 divider iterations and a final add. Throughput:
// one raw draw per cycle while results are taken; no request during a remainder loop.
// Reset loads both seed registers and both generator words with 0xFEEDFACECAFEBEEF.
module prng_with_range_reduction_core
   import prng_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*WORD_W-1:0]    req_tdata,   // range_low [63:0], range_high [127:64]
   input  logic [MODE_W-1:0]      req_tuser,   // mode [1:0]
   // Result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [WORD_W-1:0]      rsp_tdata,   // value [63:0]
   output logic                   rsp_tuser,   // span_zero [0]
   // Configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type         state_ff,     state_in;
   gen_state_type     gen_ff,       gen_in;
   logic [WORD_W-1:0] seed_low_ff,  seed_low_in;
   logic [WORD_W-1:0] seed_high_ff, seed_high_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_flag_ff,  rsp_flag_in;
   logic [WORD_W-1:0] rem_ff,       rem_in;
   logic [WORD_W-1:0] dvd_ff,       dvd_in;
   logic [WORD_W-1:0] span_ff,      span_in;
   logic [WORD_W-1:0] low_ff,       low_in;
   logic [CNT_W-1:0]  cnt_ff,       cnt_in;

   logic              req_fire;
   logic              out_free;
   logic [WORD_W-1:0] req_low;
   logic [WORD_W-1:0] req_high;
   logic [WORD_W-1:0] draw_sum;
   logic [WORD_W-1:0] req_span;
   logic [WORD_W:0]   rem_shift;
   logic              rem_ge;
   logic [WORD_W:0]   rem_diff;

   assign req_low   = req_tdata[WORD_W-1:0];
   assign req_high  = req_tdata[2*WORD_W-1:WORD_W];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign draw_sum = gen_ff.word_a + gen_ff.word_b;
   assign req_span = req_high - req_low;

   // Shared remainder step: shift in one dividend bit, subtract the span if it fits.
   assign rem_shift = {rem_ff, dvd_ff[WORD_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, span_ff};
   assign rem_diff  = rem_shift - {1'b0, span_ff};

   // Next-state logic for the sequencer, generator and result register.
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      seed_low_in  = seed_low_ff;
      seed_high_in = seed_high_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      span_in      = span_ff;
      low_in       = low_ff;
      cnt_in       = cnt_ff;

      // Seed register writes.
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SEED_LOW) begin
            seed_low_in = csr_data;
         end else begin
            seed_high_in = csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_value_in = '0;
               rsp_flag_in  = 1'b0;
               case (req_tuser)
                  MODE_RAW: begin
                     gen_in       = gen_advance(gen_ff);
                     rsp_value_in = draw_sum;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_RANGE: begin
                     gen_in = gen_advance(gen_ff);
                     if (req_span == '0) begin
                        rsp_value_in = req_low;
                        rsp_flag_in  = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        rem_in   = '0;
                        dvd_in   = draw_sum;
                        span_in  = req_span;
                        low_in   = req_low;
                        cnt_in   = DIV_LAST;
                        state_in = ST_DIVIDE;
                     end
                  end
                  MODE_RESEED: begin
                     gen_in.word_a = seed_low_ff;
                     gen_in.word_b = seed_high_ff;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     // Unused mode: state untouched, zero result.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_value_in = low_ff + rem_ff;
               rsp_flag_in  = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, generator, seeds and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         gen_ff.word_a <= SEED_RESET;
         gen_ff.word_b <= SEED_RESET;
         seed_low_ff   <= SEED_RESET;
         seed_high_ff  <= SEED_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         gen_ff        <= gen_in;
         seed_low_ff   <= seed_low_in;
         seed_high_ff  <= seed_high_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      span_ff      <= span_in;
      low_ff       <= low_in;
      cnt_ff       <= cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_flag_ff;

`ifndef NO_ASSERTIONS
   // The partial remainder always stays below the divisor.
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < span_ff))
      else $error("remainder reached the span");

   // An accepted request either produces a result or starts the divider.
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || state_ff == ST_DIVIDE))
      else $error("accepted request neither answered nor dividing");

   // No request is taken while the divider is busy.
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request channel ready while busy");

   // The last divider iteration hands over to the final add.
   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && cnt_ff == '0) |=> (state_ff == ST_EMIT))
      else $error("divider did not finish after its last iteration");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for prng_with_range_reduction_core: raw, ranged, reseed and unused
// requests, with a generator model updated on each request transaction. Depends on prng_pkg.
module tb;
   import prng_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 200;
   localparam int TAIL_CYCLES = 70;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              span_zero;
   } draw_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [2*WORD_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]   req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [WORD_W-1:0]   rsp_tdata;
   logic                rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [WORD_W-1:0]   csr_data = '0;

   // Generator model: state words and seed registers as the block holds them.
   logic [WORD_W-1:0] gen_a = SEED_RESET;
   logic [WORD_W-1:0] gen_b = SEED_RESET;
   logic [WORD_W-1:0] seed_low = SEED_RESET;
   logic [WORD_W-1:0] seed_high = SEED_RESET;

   draw_result_type expected_draws[$];
   int              fail_count = 0;
   int              req_idle_pct = 0;
   int              rsp_idle_pct = 0;
   int              hold_order = 0;
   int              hold_seen = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;

   prng_with_range_reduction_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // One generator step: returns the sum of both words and moves the state on.
   function automatic logic [WORD_W-1:0] advance_generator();
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] mix;
      sum   = gen_a + gen_b;
      mix   = gen_a ^ gen_b;
      gen_a = {gen_a[39:0], gen_a[63:40]} ^ mix ^ (mix << 16);
      gen_b = {mix[26:0], mix[63:27]};
      return sum;
   endfunction

   // Expected result of one request; updates the model state.
   function automatic draw_result_type predict_request(input logic [MODE_W-1:0] mode,
                                                      input logic [WORD_W-1:0] low,
                                                      input logic [WORD_W-1:0] high);
      draw_result_type   res;
      logic [WORD_W-1:0] draw;
      logic [WORD_W-1:0] span;
      res = '0;
      case (mode)
         MODE_RAW: begin
            res.value = advance_generator();
         end
         MODE_RANGE: begin
            draw = advance_generator();
            span = high - low;
            if (span == '0) begin
               res.value     = low;
               res.span_zero = 1'b1;
            end else begin
               res.value = low + (draw % span);
            end
         end
         MODE_RESEED: begin
            gen_a = seed_low;
            gen_b = seed_high;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Bound pairs for ranged draws, biased toward small, equal, inverted and huge spans.
   function automatic void pick_bounds(output logic [WORD_W-1:0] low,
                                       output logic [WORD_W-1:0] high);
      low  = random_word();
      high = random_word();
      case ($urandom_range(7))
         2: high = low + 64'($urandom_range(1, 16));
         3: high = low;
         4: high = low - 64'($urandom_range(1, 1000));
         5: high = low + (64'd1 << $urandom_range(63));
         6: begin
            low  = '0;
            high = {32'd0, $urandom()};
         end
         7: high = low + (ALL_ONES - 64'($urandom_range(0, 3)));
         default: ;
      endcase
   endfunction

   // Presents one request, with an optional idle gap first, and records its
   // expected result once the transaction takes place. Valid stays high on return.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [WORD_W-1:0] low,
                               input logic [WORD_W-1:0] high);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {high, low};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      expected_draws.push_back(predict_request(mode, low, high));
   endtask

   // Stops offering requests and waits for every outstanding result.
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_SEED_LOW) seed_low = data;
      else seed_high = data;
   endtask

   // Writes both seed registers; only called while the block is drained.
   task automatic set_seeds(input logic [WORD_W-1:0] low_word,
                            input logic [WORD_W-1:0] high_word);
      drain_requests();
      write_csr(CSR_SEED_LOW, low_word);
      write_csr(CSR_SEED_HIGH, high_word);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   // Field extremes, every mode, zero span, inverted bounds and ignored range inputs.
   task automatic test_directed_requests();
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] high;
      send_request(MODE_RAW, '0, '0);
      send_request(MODE_RAW, ALL_ONES, ALL_ONES);
      send_request(MODE_RANGE, '0, ALL_ONES);
      send_request(MODE_RANGE, ALL_ONES, '0);
      send_request(MODE_RANGE, 64'd5, 64'd5);
      send_request(MODE_RANGE, ALL_ONES, ALL_ONES);
      send_request(MODE_RANGE, '0, '0);
      send_request(MODE_RANGE, 64'd100, 64'd101);
      send_request(MODE_RANGE, 64'd1000, 64'd7);
      send_request(MODE_RANGE, '0, 64'h8000_0000_0000_0000);
      pick_bounds(low, high);
      send_request(MODE_RANGE, low, high);
      send_request(MODE_UNUSED, ALL_ONES, ALL_ONES);
      send_request(MODE_UNUSED, '0, '0);
      send_request(MODE_RESEED, ALL_ONES, 64'd3);
      send_request(MODE_RAW, '0, '0);
      send_request(MODE_RANGE, '0, 64'd10);
      drain_requests();
   endtask

   // Seed registers at the extremes: an all-zero seed holds the generator at zero.
   task automatic test_seed_registers();
      set_seeds('0, '0);
      send_request(MODE_RESEED, '0, '0);
      send_request(MODE_RAW, '0, '0);
      send_request(MODE_RANGE, 64'd3, 64'd9);
      send_request(MODE_RANGE, 64'd9, 64'd9);
      set_seeds(ALL_ONES, '0);
      send_request(MODE_RESEED, '0, '0);
      send_request(MODE_RAW, '0, '0);
      send_request(MODE_RANGE, 64'd1, 64'd77);
      set_seeds(random_word(), random_word());
      send_request(MODE_RESEED, '0, '0);
      send_request(MODE_RAW, '0, '0);
      send_request(MODE_RAW, '0, '0);
      drain_requests();
   endtask

   // Random mix of all modes with random operands.
   task automatic test_random_traffic(input int count);
      int                pick;
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] high;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) mode = MODE_RAW;
         else if (pick < 85) mode = MODE_RANGE;
         else if (pick < 93) mode = MODE_RESEED;
         else mode = MODE_UNUSED;
         pick_bounds(low, high);
         send_request(mode, low, high);
      end
      drain_requests();
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_result_backpressure();
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] high;
      hold_order <= hold_order + 1;
      for (int i = 0; i < 40; i++) begin
         pick_bounds(low, high);
         send_request((i % 8 == 7) ? MODE_RANGE : MODE_RAW, low, high);
      end
      drain_requests();
   endtask

   // Result side: checks each result transaction, then drives ready for the next edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               $error("result with none expected: value %h span_zero %b",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               if (rsp_tdata !== expected_draws[0].value) begin
                  $error("value: expected %h, actual %h", expected_draws[0].value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== expected_draws[0].span_zero) begin
                  $error("span_zero: expected %b, actual %b",
                         expected_draws[0].span_zero, rsp_tuser);
                  fail_count++;
               end
               void'(expected_draws.pop_front());
            end
         end
         if (hold_order != hold_seen) begin
            hold_seen = hold_order;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when no transaction happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("prng_with_range_reduction_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_requests();
      test_seed_registers();
      set_seeds(random_word(), random_word());
      set_idling(38, 86);
      test_random_traffic(230);
      set_seeds(ALL_ONES, ALL_ONES);
      set_idling(86, 38);
      test_random_traffic(230);
      set_seeds(random_word(), '0);
      set_idling(0, 0);
      test_random_traffic(240);
      test_result_backpressure();
      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_draws.size() == 0)
         $display("prng_with_range_reduction_core verification clean");
      else
         $display("prng_with_range_reduction_core verification failed");
      $finish;
   end

endmodule
